### rtl/region_histogram_statistics_macros.svh
// Assertion macros shared by the region statistics RTL.
`ifndef REGION_HISTOGRAM_STATISTICS_MACROS_SVH
`define REGION_HISTOGRAM_STATISTICS_MACROS_SVH
`ifndef ASSERT_OFF
`define RHS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define RHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RHS_ASSERT(lbl, cond, msg)
`define RHS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/rhs_pkg.sv
// Types, constants and helper functions of the region statistics block.
`timescale 1ns / 1ps
package rhs_pkg;

    localparam int PIX_W    = 16;
    localparam int COORD_W  = 13;
    localparam int FIX_W    = 24;
    localparam int OUT_W    = 176;
    localparam int OP_W     = 64;
    localparam int MUL_STEPS  = 64;
    localparam int DIV_STEPS  = 128;
    localparam int SQRT_STEPS = 32;
    localparam logic [16:0] RECIP3 = 17'd43691;

    localparam logic [1:0] REG_RX = 2'd0;
    localparam logic [1:0] REG_RY = 2'd1;
    localparam logic [1:0] REG_RW = 2'd2;
    localparam logic [1:0] REG_RH = 2'd3;

    typedef enum logic [2:0] {
        T_CLEAR, T_RUN, T_DRAIN, T_WALK, T_REG, T_CEN, T_LOAD
    } t_top_state;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_CHK, ST_SDDIV, ST_SQRT, ST_MDIV, ST_DONE
    } t_stat_state;

    typedef struct packed {
        logic              start;
        logic [OP_W-1:0]   n;
        logic [OP_W-1:0]   s;
        logic [OP_W-1:0]   s2;
        logic [PIX_W-1:0]  lo;
        logic [PIX_W-1:0]  hi;
    } t_stat_req;

    typedef struct packed {
        logic              done;
        logic [FIX_W-1:0]  mean;
        logic [FIX_W-1:0]  sd;
    } t_stat_rsp;

    function automatic logic [FIX_W-1:0] sat24(input logic [OP_W-1:0] v);
        return (|v[OP_W-1:FIX_W]) ? {FIX_W{1'b1}} : v[FIX_W-1:0];
    endfunction

    // exact v/3 for any 16-bit v
    function automatic logic [PIX_W-1:0] div3(input logic [PIX_W-1:0] v);
        logic [32:0] pr;
        pr = 33'(v) * 33'(RECIP3);
        return pr[32:17];
    endfunction

endpackage

### rtl/rhs_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rhs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/rhs_stat.sv
// Mean and sample deviation unit: serial multiply, restoring divide, integer root.
`timescale 1ns / 1ps
module rhs_stat import rhs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stat_req i_req,
    output t_stat_rsp o_rsp
);
    t_stat_state r_state, n_state;
    logic [6:0]        r_k;
    logic [OP_W-1:0]   r_n, r_s, r_m1, r_m2, r_m3, r_b, r_r, r_div, r_v, r_res, r_bit;
    logic [127:0]      r_sn, r_ss, r_p, r_q, r_dv;
    logic [FIX_W-1:0]  r_mean, r_sd;
    logic [16:0]       fb_sum;
    logic [PIX_W-1:0]  fb_diff;
    logic              d_ge;
    logic [OP_W-1:0]   d_rs, d_r;
    logic [127:0]      d_dv, diff;
    logic [OP_W-1:0]   sq_t, sq_res;

    // one restoring divide step, one root step, the variance difference and the n <= 1 fallback values
    always_comb begin
        d_rs = {r_r[OP_W-2:0], r_dv[127]};
        d_ge = r_r[OP_W-1] | (d_rs >= r_div);
        d_r  = d_ge ? d_rs - r_div : d_rs;
        d_dv = {r_dv[126:0], d_ge};
        sq_t = r_res + r_bit;
        sq_res = (r_v >= sq_t) ? (r_res >> 1) + r_bit : r_res >> 1;
        diff = r_p - r_q;
        fb_sum  = {1'b0, i_req.lo} + {1'b0, i_req.hi};
        fb_diff = (i_req.hi >= i_req.lo) ? i_req.hi - i_req.lo : '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_req.start) n_state = (i_req.n <= 64'd1) ? ST_DONE : ST_MUL;
            ST_MUL:   if (r_k == 7'(MUL_STEPS - 1)) n_state = ST_CHK;
            ST_CHK:   n_state = (r_p > r_q) ? ST_SDDIV : ST_MDIV;
            ST_SDDIV: if (r_k == 7'(DIV_STEPS - 1)) n_state = ST_SQRT;
            ST_SQRT:  if (r_k == 7'(SQRT_STEPS - 1)) n_state = ST_MDIV;
            ST_MDIV:  if (r_k == 7'(DIV_STEPS - 1)) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == ST_DONE);
        o_rsp.mean = r_mean;
        o_rsp.sd   = r_sd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_k <= (n_state != r_state) ? '0 : r_k + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_n  <= i_req.n;
                r_s  <= i_req.s;
                r_sn <= {64'd0, i_req.n};
                r_ss <= {64'd0, i_req.s};
                r_m1 <= i_req.s2;
                r_m2 <= i_req.s;
                r_m3 <= i_req.n - 64'd1;
                r_p  <= '0;
                r_q  <= '0;
                r_b  <= '0;
                r_mean <= {fb_sum[16:1], 8'd0};
                r_sd   <= {div3(fb_diff), 8'd0};
            end
            ST_MUL: begin
                if (r_m1[0]) r_p <= r_p + r_sn;
                if (r_m2[0]) r_q <= r_q + r_ss;
                if (r_m3[0]) r_b <= r_b + r_sn[OP_W-1:0];
                r_sn <= {r_sn[126:0], 1'b0};
                r_ss <= {r_ss[126:0], 1'b0};
                r_m1 <= r_m1 >> 1;
                r_m2 <= r_m2 >> 1;
                r_m3 <= r_m3 >> 1;
            end
            ST_CHK: begin
                r_r <= '0;
                if (r_p > r_q) begin
                    r_dv  <= {diff[111:0], 16'd0};
                    r_div <= r_b;
                end else begin
                    r_sd  <= '0;
                    r_dv  <= {64'd0, r_s[OP_W-9:0], 8'd0};
                    r_div <= r_n;
                end
            end
            ST_SDDIV: begin
                r_r  <= d_r;
                r_dv <= d_dv;
                if (r_k == 7'(DIV_STEPS - 1)) begin
                    r_v   <= (|d_dv[127:64]) ? {OP_W{1'b1}} : d_dv[63:0];
                    r_res <= '0;
                    r_bit <= 64'h4000_0000_0000_0000;
                end
            end
            ST_SQRT: begin
                if (r_v >= sq_t) r_v <= r_v - sq_t;
                r_res <= sq_res;
                r_bit <= r_bit >> 2;
                if (r_k == 7'(SQRT_STEPS - 1)) begin
                    r_sd  <= sat24(sq_res);
                    r_r   <= '0;
                    r_dv  <= {64'd0, r_s[OP_W-9:0], 8'd0};
                    r_div <= r_n;
                end
            end
            ST_MDIV: begin
                r_r  <= d_r;
                r_dv <= d_dv;
                if (r_k == 7'(DIV_STEPS - 1)) r_mean <= sat24(d_dv[63:0]);
            end
            ST_DONE: ;
            default: ;
        endcase
    end
endmodule

### rtl/region_histogram_statistics.sv
// Top level: pixel intake, histogram update and walk, result sequencing.
`timescale 1ns / 1ps
`include "region_histogram_statistics_macros.svh"
// Region statistics. Pixels of a region enter one per cycle on s_t* while the
// block takes items; each item updates min/max, sums and a histogram held in
// one RAM (read, increment, write back, with a one-entry forward for repeated bins).
// After the last pixel the block stops taking items during a histogram walk
// up to the bin of the maximum, which also zeroes the bins it passes, and two
// jobs of the shared statistics unit (64 multiply steps, two 128-step divides
// and a 32-step root), then one result item goes to the m_t* output register;
// the next region may stream in while it waits there. After reset a clearing
// pass over all HIST_BINS bins zeroes the histogram before any item is taken.
module region_histogram_statistics import rhs_pkg::*; #(
    parameter int HIST_BINS  = 65536,
    parameter int MAX_DIM    = 4096,
    parameter int COUNT_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // pixel[15:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    // min_value[15:0], max_value[31:16], max_col[44:32], max_row[57:45],
    // mean[81:58], std_dev[105:82], median[121:106], central_mean[145:122],
    // central_std[169:146], zeros above
    output logic [OUT_W-1:0]  m_tdata
);
    localparam int BIN_W  = $clog2(HIST_BINS);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int RN_W   = 2 * DIM_W;
    localparam int SUM_W  = (RN_W + 16 > 64) ? 64 : RN_W + 16;
    localparam int SUM2_W = (RN_W + 32 > 64) ? 64 : RN_W + 32;
    localparam int CS_W   = (RN_W + BIN_W > 64) ? 64 : RN_W + BIN_W;
    localparam int CS2_W  = (RN_W + 2 * BIN_W > 64) ? 64 : RN_W + 2 * BIN_W;
    localparam int P1_W   = BIN_W + COUNT_BITS;
    localparam int P2_W   = 2 * BIN_W + COUNT_BITS;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [12:0] v);
        logic [16:0] w;
        w = 17'(v);
        if (w == 17'd0) return DIM_W'(1);
        if (w > 17'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return DIM_W'(w);
    endfunction

    function automatic logic [BIN_W-1:0] to_bin(input logic [PIX_W-1:0] p);
        return (17'(p) >= 17'(HIST_BINS)) ? BIN_W'(HIST_BINS - 1) : p[BIN_W-1:0];
    endfunction

    t_top_state r_state, n_state;

    // configuration
    logic [11:0] r_rx, r_ry;
    logic [12:0] r_rw, r_rh;
    logic        apb_wr;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic [RN_W-1:0]  rn;

    // region accumulation
    logic              s_acc, last, first;
    logic [RN_W-1:0]   r_cnt, r_rn;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM2_W-1:0] r_sum2;
    logic [PIX_W-1:0]  r_min, r_max;
    logic [COORD_W-1:0] r_pc, r_pr;
    logic [11:0]       r_col, r_row;
    logic [31:0]       sq;
    logic [BIN_W-1:0]  pix_bin;

    // histogram update stage
    logic                  r_s_v, r_fw_v;
    logic [BIN_W-1:0]      r_s_bin, r_fw_bin;
    logic [COUNT_BITS-1:0] r_fw_val, fw_old, hist_new;

    // memory port
    logic                  ram_we;
    logic [BIN_W-1:0]      ram_wa, ram_ra;
    logic [COUNT_BITS-1:0] ram_wd, ram_rd;

    // walk
    logic [BIN_W:0]        r_wa;
    logic [BIN_W-1:0]      r_wlast;
    logic                  wk_issue, walk_done, clr_end;
    logic                  r_a_v, r_b_v, r_c_v;
    logic [BIN_W-1:0]      r_a_idx, r_b_idx;
    logic [COUNT_BITS-1:0] r_b_h;
    logic [2*BIN_W-1:0]    r_b_ii;
    logic [P1_W-1:0]       r_c_p1;
    logic [P2_W-1:0]       r_c_p2;
    logic [RN_W-1:0]       r_n, r_x, r_t25, r_t50, r_t75, wa_n;
    logic [RN_W+1:0]       rn3;
    logic [CS_W-1:0]       r_cs;
    logic [CS2_W-1:0]      r_cs2;
    logic                  r_won, r_h25, r_h50, f25, f50, cen;
    logic [PIX_W-1:0]      r_lo, r_hi;

    // statistics unit
    t_stat_req st_req;
    t_stat_rsp st_rsp;
    logic      r_go;
    logic [FIX_W-1:0] r_mean, r_sd, r_cmean, r_csd;

    // output
    logic             r_ov, load_go;
    logic [OUT_W-1:0] r_od;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign apb_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx <= '0;
            r_ry <= '0;
            r_rw <= 13'd1;
            r_rh <= 13'd1;
        end else if (apb_wr) begin
            unique case (paddr[3:2])
                REG_RX:  r_rx <= pwdata[11:0];
                REG_RY:  r_ry <= pwdata[11:0];
                REG_RW:  r_rw <= pwdata[12:0];
                REG_RH:  r_rh <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RX:  prdata = {20'd0, r_rx};
            REG_RY:  prdata = {20'd0, r_ry};
            REG_RW:  prdata = {19'd0, r_rw};
            REG_RH:  prdata = {19'd0, r_rh};
            default: prdata = '0;
        endcase
    end

    // ---------------- combinational helpers ----------------
    always_comb begin
        eff_w   = eff_dim(r_rw);
        eff_h   = eff_dim(r_rh);
        rn      = RN_W'(eff_w) * RN_W'(eff_h);
        s_acc   = s_tvalid & s_tready;
        last    = (RN_W+1)'(r_cnt) + (RN_W+1)'(1) >= (RN_W+1)'(rn);
        first   = (r_cnt == '0);
        sq      = 32'(s_tdata) * 32'(s_tdata);
        pix_bin = to_bin(s_tdata);
        fw_old   = (r_fw_v && r_fw_bin == r_s_bin) ? r_fw_val : ram_rd;
        hist_new = (&fw_old) ? fw_old : fw_old + COUNT_BITS'(1);
        rn3     = (RN_W+2)'(r_rn) + (RN_W+2)'({r_rn, 1'b0});
        wa_n    = r_n + RN_W'(ram_rd);
        f50     = !r_h50 && (wa_n >= r_t50);
        f25     = !r_h25 && (wa_n >= r_t25);
        cen     = r_h25 | f25;
        clr_end = (r_wa == (BIN_W+1)'(HIST_BINS - 1));
        load_go = !r_ov || m_tready;
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_CLEAR: if (clr_end) n_state = T_RUN;
            T_RUN:   if (s_acc && last) n_state = T_DRAIN;
            T_DRAIN: n_state = T_WALK;
            T_WALK:  if (walk_done) n_state = T_REG;
            T_REG:   if (st_rsp.done) n_state = T_CEN;
            T_CEN:   if (st_rsp.done) n_state = T_LOAD;
            T_LOAD:  if (load_go) n_state = T_RUN;
            default: n_state = T_CLEAR;
        endcase
    end

    always_comb begin
        s_tready = (r_state == T_RUN);
        wk_issue = (r_state == T_WALK) && (r_wa <= {1'b0, r_wlast});
        walk_done = !wk_issue && !r_a_v && !r_b_v && !r_c_v;
        ram_ra = (r_state == T_RUN) ? pix_bin : r_wa[BIN_W-1:0];
        if (r_state == T_CLEAR) begin
            ram_we = 1'b1;
            ram_wa = r_wa[BIN_W-1:0];
            ram_wd = '0;
        end else if (r_s_v) begin
            ram_we = 1'b1;
            ram_wa = r_s_bin;
            ram_wd = hist_new;
        end else begin
            // walk zeroes each bin it reads
            ram_we = r_a_v;
            ram_wa = r_a_idx;
            ram_wd = '0;
        end
        st_req.start = r_go;
        if (r_state == T_REG) begin
            st_req.n  = 64'(r_rn);
            st_req.s  = 64'(r_sum);
            st_req.s2 = 64'(r_sum2);
            st_req.lo = r_min;
            st_req.hi = r_max;
        end else begin
            st_req.n  = 64'(r_x);
            st_req.s  = 64'(r_cs);
            st_req.s2 = 64'(r_cs2);
            st_req.lo = r_lo;
            st_req.hi = r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_CLEAR;
            r_go    <= 1'b0;
            r_s_v   <= 1'b0;
            r_fw_v  <= 1'b0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_ov    <= 1'b0;
            r_wa    <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sum2  <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state) && (n_state == T_REG || n_state == T_CEN);
            r_s_v   <= s_acc;
            r_fw_v  <= r_s_v;
            r_a_v   <= wk_issue;
            r_b_v   <= r_a_v && r_won && cen;
            r_c_v   <= r_b_v;

            if (r_state == T_CLEAR || wk_issue) r_wa <= r_wa + (BIN_W+1)'(1);
            if (r_state == T_DRAIN) r_wa <= '0;

            if (s_acc) begin
                r_cnt  <= r_cnt + RN_W'(1);
                r_sum  <= r_sum + SUM_W'(s_tdata);
                r_sum2 <= r_sum2 + SUM2_W'(sq);
                if (17'(r_col) + 17'd1 >= 17'(eff_w)) begin
                    r_col <= '0;
                    r_row <= r_row + 12'd1;
                end else begin
                    r_col <= r_col + 12'd1;
                end
            end

            if (r_state == T_LOAD && load_go) begin
                r_cnt  <= '0;
                r_sum  <= '0;
                r_sum2 <= '0;
                r_col  <= '0;
                r_row  <= '0;
            end

            if (r_state == T_LOAD && load_go) r_ov <= 1'b1;
            else if (m_tready) r_ov <= 1'b0;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            if (first) begin
                r_min <= s_tdata;
                r_max <= s_tdata;
                r_pc  <= COORD_W'(r_rx);
                r_pr  <= COORD_W'(r_ry);
            end else begin
                if (s_tdata > r_max) begin
                    r_max <= s_tdata;
                    r_pc  <= COORD_W'(r_rx) + COORD_W'(r_col);
                    r_pr  <= COORD_W'(r_ry) + COORD_W'(r_row);
                end
                if (s_tdata < r_min) r_min <= s_tdata;
            end
            if (last) r_rn <= rn;
        end
        r_s_bin  <= pix_bin;
        r_fw_bin <= r_s_bin;
        r_fw_val <= hist_new;

        // walk setup on the drain cycle
        if (r_state == T_DRAIN) begin
            r_wlast <= to_bin(r_max);
            r_n   <= '0;
            r_x   <= '0;
            r_cs  <= '0;
            r_cs2 <= '0;
            r_won <= 1'b1;
            r_h25 <= 1'b0;
            r_h50 <= 1'b0;
            r_lo  <= PIX_W'(HIST_BINS - 1);
            r_hi  <= PIX_W'(HIST_BINS - 1);
            r_t25 <= r_rn >> 2;
            r_t50 <= r_rn >> 1;
            r_t75 <= rn3[RN_W+1:2];
        end

        r_a_idx <= r_wa[BIN_W-1:0];
        if (r_a_v && r_won) begin
            r_n <= wa_n;
            if (f50) begin
                r_h50 <= 1'b1;
                r_hi  <= PIX_W'(r_a_idx);
            end
            if (f25) begin
                r_h25 <= 1'b1;
                r_lo  <= PIX_W'(r_a_idx);
            end
            if (cen) r_x <= r_x + RN_W'(ram_rd);
            if (wa_n > r_t75) r_won <= 1'b0;
        end
        r_b_idx <= r_a_idx;
        r_b_h   <= ram_rd;
        r_b_ii  <= (2*BIN_W)'(r_a_idx) * (2*BIN_W)'(r_a_idx);
        r_c_p1  <= P1_W'(r_b_idx) * P1_W'(r_b_h);
        r_c_p2  <= P2_W'(r_b_ii) * P2_W'(r_b_h);
        if (r_c_v) begin
            r_cs  <= r_cs + CS_W'(r_c_p1);
            r_cs2 <= r_cs2 + CS2_W'(r_c_p2);
        end

        if (st_rsp.done && r_state == T_REG) begin
            r_mean <= st_rsp.mean;
            r_sd   <= st_rsp.sd;
        end
        if (st_rsp.done && r_state == T_CEN) begin
            r_cmean <= st_rsp.mean;
            r_csd   <= st_rsp.sd;
        end

        if (r_state == T_LOAD && load_go) begin
            r_od <= {6'd0, r_csd, r_cmean, r_hi, r_sd, r_mean, r_pr, r_pc, r_max, r_min};
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_od;

    rhs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    rhs_stat u_stat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (st_req),
        .o_rsp   (st_rsp)
    );

    `RHS_ASSERT_NEXT(a_last_drain, s_acc && last, r_state == T_DRAIN, "last pixel not followed by drain")
    `RHS_ASSERT(a_no_wr_clash, !(r_s_v && r_a_v), "histogram update and walk write collide")
    `RHS_ASSERT(a_done_phase, !st_rsp.done || r_state == T_REG || r_state == T_CEN, "stat done out of phase")
    `RHS_ASSERT_NEXT(a_load_valid, r_state == T_LOAD && load_go, m_tvalid, "result not presented")

endmodule
